>>> hdl/zsc_pkg.sv
// zsc_pkg: shared types, constants and modular arithmetic for the zigzag subsequence counter
// no dependencies; imported by zsc_ctrl, zsc_datapath and zigzag_subsequence_counter
package zsc_pkg;

	localparam int CNT_W   = 30;
	localparam int VALUE_W = 12;
	localparam int EPOCH_W = 8;

	localparam logic [CNT_W:0] MODULUS = 31'd1000000007;

	typedef logic [CNT_W-1:0] count_t;

	typedef struct packed {
		logic [VALUE_W-1:0] sample_value;
		logic               starts_sequence;
	} sample_t;

	typedef struct packed {
		count_t ending_ascent_count;
		count_t ending_descent_count;
		count_t running_total;
	} result_t;

	typedef struct packed {
		logic sweep_step;
		logic load;
		logic query_step;
		logic calc_up;
		logic calc_down;
		logic upd_step;
		logic fin_sum;
		logic fin_total;
	} cmd_t;

	typedef struct packed {
		logic wrap_now;
		logic sweep_last;
		logic query_done;
		logic upd_done;
	} status_t;

	function automatic count_t mod_add(input count_t a, input count_t b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= MODULUS) begin
			s = s - MODULUS;
		end
		return s[CNT_W-1:0];
	endfunction

	function automatic count_t mod_sub(input count_t a, input count_t b);
		logic [CNT_W:0] d;
		if (a >= b) begin
			d = {1'b0, a} - {1'b0, b};
		end else begin
			d = {1'b0, a} + MODULUS - {1'b0, b};
		end
		return d[CNT_W-1:0];
	endfunction

endpackage

>>> hdl/zsc_ctrl.sv
// zsc_ctrl: sequencer for the zigzag subsequence counter
// depends on zsc_pkg; drives zsc_datapath commands and the word handshakes
module zsc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_stall,
	input  logic             out_free,
	output logic             out_load,
	output zsc_pkg::cmd_t    cmd,
	input  zsc_pkg::status_t status
);
	import zsc_pkg::*;

	typedef enum logic [3:0] {
		S_INIT_SWEEP,
		S_IDLE,
		S_START_SWEEP,
		S_QUERY,
		S_CALC_UP,
		S_CALC_DOWN,
		S_UPDATE,
		S_FIN_SUM,
		S_FIN_TOTAL,
		S_DELIVER
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT_SWEEP;
		end else begin
			unique case (state_q)
				S_INIT_SWEEP: begin
					if (status.sweep_last) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (sample_valid) begin
						state_q <= status.wrap_now ? S_START_SWEEP : S_QUERY;
					end
				end
				S_START_SWEEP: begin
					if (status.sweep_last) state_q <= S_QUERY;
				end
				S_QUERY: begin
					if (status.query_done) state_q <= S_CALC_UP;
				end
				S_CALC_UP:   state_q <= S_CALC_DOWN;
				S_CALC_DOWN: state_q <= S_UPDATE;
				S_UPDATE: begin
					if (status.upd_done) state_q <= S_FIN_SUM;
				end
				S_FIN_SUM:   state_q <= S_FIN_TOTAL;
				S_FIN_TOTAL: state_q <= S_DELIVER;
				S_DELIVER: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd            = '0;
		cmd.sweep_step = (state_q == S_INIT_SWEEP) || (state_q == S_START_SWEEP);
		cmd.load       = (state_q == S_IDLE) && sample_valid;
		cmd.query_step = (state_q == S_QUERY);
		cmd.calc_up    = (state_q == S_CALC_UP);
		cmd.calc_down  = (state_q == S_CALC_DOWN);
		cmd.upd_step   = (state_q == S_UPDATE);
		cmd.fin_sum    = (state_q == S_FIN_SUM);
		cmd.fin_total  = (state_q == S_FIN_TOTAL);
	end

	assign sample_stall = (state_q != S_IDLE);
	assign out_load     = (state_q == S_DELIVER) && out_free;

endmodule

>>> hdl/zsc_datapath.sv
// zsc_datapath: two Fenwick tables in memory, prefix walks, update walks and running sums
// depends on zsc_pkg; commanded by zsc_ctrl
module zsc_datapath #(
	parameter int TABLE_DEPTH = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  zsc_pkg::cmd_t    cmd,
	output zsc_pkg::status_t status,
	input  zsc_pkg::sample_t sample,
	output zsc_pkg::result_t result
);
	import zsc_pkg::*;

	localparam int AW     = $clog2(TABLE_DEPTH);
	localparam int PW     = AW + 1;
	localparam int WORD_W = EPOCH_W + CNT_W;

	localparam logic [PW-1:0] DEPTH_P  = PW'(TABLE_DEPTH);
	localparam logic [PW:0]   DEPTH_U  = (PW+1)'(TABLE_DEPTH);
	localparam logic [AW-1:0] LAST_A   = AW'(TABLE_DEPTH - 1);
	localparam logic [16:0]   DEPTH_X  = 17'(TABLE_DEPTH);
	localparam logic [16:0]   MAXVAL_X = 17'(TABLE_DEPTH - 1);
	localparam count_t        ONE      = count_t'(1);

	// each word carries the epoch it was written in; a stale epoch reads as zero
	logic [WORD_W-1:0] asc_mem [TABLE_DEPTH];
	logic [WORD_W-1:0] desc_mem [TABLE_DEPTH];
	logic [WORD_W-1:0] asc_rd_q, desc_rd_q;

	logic [EPOCH_W-1:0] epoch_q;
	logic [AW-1:0]      sweep_q;
	logic [PW-1:0]      qd_q, qa_q, u_q, pos_q;
	logic               pend_d_q, pend_a_q, wpend_q;
	logic [AW-1:0]      wr_addr_q;

	count_t acc_d_q, acc_a_q, up_q, down_q, inc_q, grand_q, total_q;

	logic [16:0]    v_ext, v_sat;
	logic [PW-1:0]  v_pos, qd_m1, qa_m1, u_m1;
	logic [PW:0]    u_ext, u_next;
	logic [AW-1:0]  rd_addr_d, rd_addr_a;
	logic           rd_en_d, rd_en_a;
	count_t         asc_val, desc_val;
	count_t         incr;

	always_comb begin
		v_ext = 17'(sample.sample_value);
		v_sat = (v_ext >= DEPTH_X) ? MAXVAL_X : v_ext;
		v_pos = v_sat[PW-1:0];
	end

	assign qd_m1  = qd_q - 1'b1;
	assign qa_m1  = qa_q - 1'b1;
	assign u_m1   = u_q - 1'b1;
	assign u_ext  = {1'b0, u_q};
	assign u_next = u_ext + (u_ext & (~u_ext + 1'b1));

	assign rd_en_d   = (cmd.query_step && (qd_q != '0)) || (cmd.upd_step && (u_q != '0));
	assign rd_en_a   = (cmd.query_step && (qa_q != '0)) || (cmd.upd_step && (u_q != '0));
	assign rd_addr_d = cmd.upd_step ? u_m1[AW-1:0] : qd_m1[AW-1:0];
	assign rd_addr_a = cmd.upd_step ? u_m1[AW-1:0] : qa_m1[AW-1:0];

	assign desc_val = (desc_rd_q[WORD_W-1 -: EPOCH_W] == epoch_q) ? desc_rd_q[CNT_W-1:0] : '0;
	assign asc_val  = (asc_rd_q[WORD_W-1 -: EPOCH_W] == epoch_q) ? asc_rd_q[CNT_W-1:0] : '0;

	// total grows by up + down - 1, a zero sum wraps to p - 1
	assign incr = mod_sub(mod_add(up_q, down_q), ONE);

	always_ff @(posedge clk) begin
		if (cmd.sweep_step) begin
			desc_mem[sweep_q] <= '0;
		end else if (wpend_q) begin
			desc_mem[wr_addr_q] <= {epoch_q, mod_add(desc_val, down_q)};
		end
		if (rd_en_d) begin
			desc_rd_q <= desc_mem[rd_addr_d];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sweep_step) begin
			asc_mem[sweep_q] <= '0;
		end else if (wpend_q) begin
			asc_mem[wr_addr_q] <= {epoch_q, mod_add(asc_val, up_q)};
		end
		if (rd_en_a) begin
			asc_rd_q <= asc_mem[rd_addr_a];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q  <= '0;
			sweep_q  <= '0;
			qd_q     <= '0;
			qa_q     <= '0;
			u_q      <= '0;
			pend_d_q <= 1'b0;
			pend_a_q <= 1'b0;
			wpend_q  <= 1'b0;
			grand_q  <= '0;
			total_q  <= '0;
		end else begin
			if (cmd.sweep_step) begin
				sweep_q <= (sweep_q == LAST_A) ? '0 : sweep_q + 1'b1;
			end

			pend_d_q <= cmd.query_step && (qd_q != '0);
			pend_a_q <= cmd.query_step && (qa_q != '0);
			wpend_q  <= cmd.upd_step && (u_q != '0);

			if (cmd.load) begin
				qd_q <= v_pos;
				qa_q <= v_pos + 1'b1;
				if (sample.starts_sequence) begin
					// wraps to zero only together with a full sweep
					epoch_q <= epoch_q + 1'b1;
					grand_q <= '0;
					total_q <= '0;
				end
			end else if (cmd.query_step) begin
				if (qd_q != '0) qd_q <= qd_q & qd_m1;
				if (qa_q != '0) qa_q <= qa_q & qa_m1;
			end

			if (cmd.calc_up) begin
				u_q <= pos_q;
			end else if (cmd.upd_step && (u_q != '0)) begin
				u_q <= (u_next > DEPTH_U) ? '0 : u_next[PW-1:0];
			end

			if (cmd.fin_sum) grand_q <= mod_add(grand_q, up_q);
			if (cmd.fin_total) total_q <= mod_add(total_q, inc_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pos_q   <= v_pos + 1'b1;
			acc_d_q <= '0;
			acc_a_q <= '0;
		end else begin
			if (pend_d_q) acc_d_q <= mod_add(acc_d_q, desc_val);
			if (pend_a_q) acc_a_q <= mod_add(acc_a_q, asc_val);
			if (cmd.calc_up) begin
				up_q    <= mod_add(ONE, acc_d_q);
				acc_a_q <= mod_sub(grand_q, acc_a_q);
			end
		end
		if (cmd.calc_down) down_q <= mod_add(ONE, acc_a_q);
		if (cmd.upd_step) wr_addr_q <= u_m1[AW-1:0];
		if (cmd.fin_sum) inc_q <= incr;
	end

	always_comb begin
		status.wrap_now   = sample.starts_sequence && (epoch_q == '1);
		status.sweep_last = (sweep_q == LAST_A);
		status.query_done = (qd_q == '0) && (qa_q == '0) && !pend_d_q && !pend_a_q;
		status.upd_done   = (u_q == '0) && !wpend_q;
	end

	assign result.ending_ascent_count  = up_q;
	assign result.ending_descent_count = down_q;
	assign result.running_total        = total_q;

	a_no_wr_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		wpend_q |-> !cmd.sweep_step)
		else $error("table write pending during clearing sweep");

	a_walk_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (qa_q == qd_q + 1'b1))
		else $error("prefix walks not one position apart after load");

	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		(u_q <= DEPTH_P) && (qa_q <= DEPTH_P))
		else $error("fenwick walk position beyond table");

endmodule

>>> hdl/zigzag_subsequence_counter.sv
// zigzag_subsequence_counter: top level, output register and handshakes
// depends on zsc_pkg, zsc_ctrl and zsc_datapath
//
// Counts, modulo 1000000007, the non-empty strictly alternating subsequences of the
// sample stream and returns one result word per sample word: the counts ending at
// this sample on an upward and on a downward step, and the running total. Samples
// at or above TABLE_DEPTH are saturated to TABLE_DEPTH - 1. One sample is in work at
// a time; from acceptance to result it runs the two Fenwick prefix walks side by side,
// then the update walks of both tables together, one memory read per walk step.
// Tables are cleared by an epoch tag in each word; every 256th word with
// starts_sequence set, and the time after reset, run a clearing sweep over all
// TABLE_DEPTH words during which no sample is taken.
// A finished result waits in an output register while the next sample is accepted.
module zigzag_subsequence_counter #(
	parameter int TABLE_DEPTH = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_stall,
	input  zsc_pkg::sample_t sample,
	output logic             result_valid,
	input  logic             result_stall,
	output zsc_pkg::result_t result
);
	import zsc_pkg::*;

	cmd_t    cmd;
	status_t status;
	result_t dp_result;
	result_t result_q;
	logic    result_valid_q;
	logic    out_free, out_load;

	assign out_free = !result_valid_q || !result_stall;

	zsc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.out_free     (out_free),
		.out_load     (out_load),
		.cmd          (cmd),
		.status       (status)
	);

	zsc_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.status (status),
		.sample (sample),
		.result (dp_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) result_q <= dp_result;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
